### rtl/tri_pkg.sv
// shared types and constants for the turn radius interpolator
// no dependencies
package tri_pkg;

    localparam int ENTRIES_DEFAULT = 16;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // result source codes
    localparam logic [2:0] SRC_EMPTY  = 3'd0;
    localparam logic [2:0] SRC_SINGLE = 3'd1;
    localparam logic [2:0] SRC_BELOW  = 3'd2;
    localparam logic [2:0] SRC_EXACT  = 3'd3;
    localparam logic [2:0] SRC_ABOVE  = 3'd4;
    localparam logic [2:0] SRC_INTERP = 3'd5;

    typedef struct packed {
        logic        command;
        logic [3:0]  entry_index;
        logic [15:0] entry_speed;
        logic [15:0] entry_radius;
        logic [15:0] query_speed;
    } in_item_t;

    typedef struct packed {
        logic [15:0] radius_q4;
        logic [2:0]  result_source;
    } out_item_t;

    // item as held in the queue, with its class worked out
    typedef struct packed {
        in_item_t item;
        logic     write_ok;
    } queued_t;

    // one breakpoint as stored in the table memory
    typedef struct packed {
        logic [15:0] speed;
        logic [15:0] radius;
    } breakpoint_t;

endpackage

### rtl/tri_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module tri_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/tri_queue.sv
// front part: accepts items, classifies them and holds them in a two-entry queue
// depends on tri_pkg
module tri_queue #(
    parameter int ENTRIES = tri_pkg::ENTRIES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tri_pkg::in_item_t item,
    output logic             head_valid,
    output tri_pkg::queued_t head,
    input  logic             pop
);

    tri_pkg::queued_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    tri_pkg::queued_t incoming;

    assign busy       = (count_reg == 2'd2);
    assign push       = start && !busy;
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

    // classify: a write beyond the table is dropped by the engine
    always_comb
    begin
        incoming.item     = item;
        incoming.write_ok = (item.command == tri_pkg::CMD_WRITE)
                            && (32'(item.entry_index) < ENTRIES);
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/tri_divider.sv
// iterative restoring divider, one quotient bit per cycle
// requires dividend[31:16] < divisor; no dependencies
module tri_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic        run_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [15:0] low_reg;
    logic [15:0] den_reg;
    logic        done_reg;
    logic [16:0] trial;
    logic        fits;

    assign trial    = {rem_reg, low_reg[15]};
    assign fits     = (trial >= {1'b0, den_reg});
    assign done     = done_reg;
    assign quotient = low_reg;

    // datapath: remainder and shifting dividend/quotient word
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[31:16];
            low_reg <= dividend[15:0];
            den_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
            low_reg <= {low_reg[14:0], fits};
        end
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= 4'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 4'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/tri_engine.sv
// back part: stores breakpoints, scans the table and interpolates queries
// depends on tri_pkg, tri_ram, tri_divider
module tri_engine #(
    parameter int ENTRIES = tri_pkg::ENTRIES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [4:0]        entries_in_use,
    input  logic              head_valid,
    input  tri_pkg::queued_t  head,
    output logic              pop,
    output logic              done,
    output tri_pkg::out_item_t result
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT,
        S_CHECK,
        S_MUL,
        S_DIV
    } state_t;

    state_t              state_reg;
    logic [IDX_W-1:0]    addr_reg;
    logic [CNT_W-1:0]    n_reg;
    logic                first_reg;
    logic [15:0]         q_reg;
    tri_pkg::breakpoint_t prev_reg;
    tri_pkg::breakpoint_t high_reg;
    logic                neg_reg;
    logic                div_start_reg;
    logic [31:0]         prod_reg;
    logic [15:0]         den_reg;
    logic                done_reg;
    tri_pkg::out_item_t  result_reg;

    logic [CNT_W-1:0]    n_eff;
    logic [31:0]         rd_raw;
    tri_pkg::breakpoint_t rd_entry;
    tri_pkg::breakpoint_t wr_entry;
    logic                ram_we;
    logic                div_done;
    logic [15:0]         quot;
    logic [15:0]         dq, mag, den;

    assign pop    = (state_reg == S_IDLE) && head_valid;
    assign done   = done_reg;
    assign result = result_reg;

    // active count, clamped to the table size
    assign n_eff = (32'(entries_in_use) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(entries_in_use);

    // table memory
    assign ram_we             = pop && head.write_ok;
    assign wr_entry.speed     = head.item.entry_speed;
    assign wr_entry.radius    = head.item.entry_radius;
    assign rd_entry           = tri_pkg::breakpoint_t'(rd_raw);

    tri_ram #(
        .WIDTH ($bits(tri_pkg::breakpoint_t)),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (IDX_W'(head.item.entry_index)),
        .wr_data (32'(wr_entry)),
        .rd_addr (addr_reg),
        .rd_data (rd_raw)
    );

    // interpolation operands
    assign dq  = q_reg - prev_reg.speed;
    assign mag = neg_reg ? (prev_reg.radius - high_reg.radius)
                         : (high_reg.radius - prev_reg.radius);
    assign den = high_reg.speed - prev_reg.speed;

    tri_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quot)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            div_start_reg <= 1'b0;
            addr_reg      <= '0;
            n_reg         <= '0;
            first_reg     <= 1'b0;
            q_reg         <= '0;
            prev_reg      <= '0;
            high_reg      <= '0;
            neg_reg       <= 1'b0;
            prod_reg      <= '0;
            den_reg       <= '0;
            result_reg    <= '0;
        end
        else
        begin
            done_reg      <= 1'b0;
            div_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop && head.item.command == tri_pkg::CMD_QUERY)
                    begin
                        q_reg <= head.item.query_speed;
                        n_reg <= n_eff;
                        if (n_eff == '0)
                        begin
                            result_reg.radius_q4     <= 16'd0;
                            result_reg.result_source <= tri_pkg::SRC_EMPTY;
                            done_reg                 <= 1'b1;
                        end
                        else
                        begin
                            addr_reg  <= '0;
                            first_reg <= 1'b1;
                            state_reg <= S_WAIT;
                        end
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    priority if (first_reg)
                    begin
                        priority if (n_reg == CNT_W'(1))
                        begin
                            result_reg.radius_q4     <= rd_entry.radius;
                            result_reg.result_source <= tri_pkg::SRC_SINGLE;
                            done_reg                 <= 1'b1;
                            state_reg                <= S_IDLE;
                        end
                        else if (q_reg <= rd_entry.speed)
                        begin
                            result_reg.radius_q4     <= rd_entry.radius;
                            result_reg.result_source <= tri_pkg::SRC_BELOW;
                            done_reg                 <= 1'b1;
                            state_reg                <= S_IDLE;
                        end
                        else
                        begin
                            prev_reg  <= rd_entry;
                            first_reg <= 1'b0;
                            addr_reg  <= IDX_W'(1);
                            state_reg <= S_WAIT;
                        end
                    end
                    else if (rd_entry.speed < q_reg)
                    begin
                        prev_reg <= rd_entry;
                        if (CNT_W'(addr_reg) + CNT_W'(1) == n_reg)
                        begin
                            result_reg.radius_q4     <= rd_entry.radius;
                            result_reg.result_source <= tri_pkg::SRC_ABOVE;
                            done_reg                 <= 1'b1;
                            state_reg                <= S_IDLE;
                        end
                        else
                        begin
                            addr_reg  <= addr_reg + IDX_W'(1);
                            state_reg <= S_WAIT;
                        end
                    end
                    else if (rd_entry.speed == q_reg)
                    begin
                        result_reg.radius_q4     <= rd_entry.radius;
                        result_reg.result_source <= tri_pkg::SRC_EXACT;
                        done_reg                 <= 1'b1;
                        state_reg                <= S_IDLE;
                    end
                    else
                    begin
                        high_reg  <= rd_entry;
                        neg_reg   <= (rd_entry.radius < prev_reg.radius);
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // product of magnitudes; sign applied after the divide
                    if (den == 16'd0)
                    begin
                        result_reg.radius_q4     <= prev_reg.radius;
                        result_reg.result_source <= tri_pkg::SRC_INTERP;
                        done_reg                 <= 1'b1;
                        state_reg                <= S_IDLE;
                    end
                    else
                    begin
                        prod_reg      <= 32'(dq) * 32'(mag);
                        den_reg       <= den;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        result_reg.radius_q4     <= neg_reg ? (prev_reg.radius - quot)
                                                            : (prev_reg.radius + quot);
                        result_reg.result_source <= tri_pkg::SRC_INTERP;
                        done_reg                 <= 1'b1;
                        state_reg                <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/turn_radius_interpolator.sv
// top level of the turn radius interpolator: config register, queue and engine
// depends on tri_pkg, tri_queue, tri_engine
//
// Items are accepted when start is high and busy is low; a two-entry queue
// takes items while the engine works. A write item stores one breakpoint, or
// is dropped if its index lies beyond the table. A query scans the breakpoints
// one at a time through the registered-read table memory, a wait state and a
// check state per breakpoint, then for an interpolated answer spends a
// multiply step and a divider run. The breakpoints in use are entries_in_use
// clamped to ENTRIES; an item waiting in the queue waits for the items ahead
// of it. Each result appears for one cycle with done high; the receiver
// cannot stall, so it must take it then. entries_in_use may only be written
// while no item is in flight.
module turn_radius_interpolator #(
    parameter int ENTRIES = tri_pkg::ENTRIES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tri_pkg::in_item_t  item,
    output logic               done,
    output tri_pkg::out_item_t result,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_data
);

    logic [4:0]       entries_in_use_reg;
    logic             head_valid;
    tri_pkg::queued_t head;
    logic             pop;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= 5'd0;
        end
        else if (cfg_we)
        begin
            entries_in_use_reg <= cfg_data;
        end
    end

    tri_queue #(
        .ENTRIES (ENTRIES)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    tri_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .entries_in_use (entries_in_use_reg),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop),
        .done           (done),
        .result         (result)
    );

endmodule
